// ===== hdl/pearson_correlation_kernel_assert.svh =====
// Assertion macros used by the checker file of this block.
// Each macro takes a label, the clock, the reset, an antecedent and a consequent.
`ifndef PEARSON_CORRELATION_KERNEL_ASSERT_SVH
`define PEARSON_CORRELATION_KERNEL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCK_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pearson_correlation_kernel: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PCK_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pearson_correlation_kernel: assertion failed");

`endif

// ===== hdl/pck_pkg.sv =====
package pck_pkg;

  // Group length and sample range.
  localparam int RECORD_LEN  = 16;
  localparam int SAMPLE_BITS = 24;

  // Field and datapath widths.
  localparam int SAMPLE_W  = 24;
  localparam int SUM_W     = 32;
  localparam int SQ_W      = 56;
  localparam int DW        = 64;
  localparam int MUL_W     = 32;
  localparam int CORR_W    = 16;
  localparam int Q_W       = CORR_W - 1;
  localparam int N_W       = $clog2(RECORD_LEN + 1);
  localparam int ISQ_STEPS = DW / 2;
  localparam int STEP_W    = $clog2(ISQ_STEPS);

  localparam logic [SAMPLE_W-1:0] SAMPLE_TOP = SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);
  localparam logic [N_W-1:0]      N_CONST    = N_W'(RECORD_LEN);

  // Operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL
  } alu_op_t;

  typedef struct packed {
    alu_op_t         op;
    logic [DW-1:0]   a;
    logic [DW-1:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic [DW-1:0]   y;
    logic            borrow;
  } alu_rsp_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_XX_MUL,
    S_XX_ADD,
    S_YY_MUL,
    S_YY_ADD,
    S_XY_MUL,
    S_XY_ADD,
    S_SX_ADD,
    S_SY_ADD,
    S_NXY,
    S_SXSY_MUL,
    S_MAG_AB,
    S_MAG_BA,
    S_NSQ,
    S_SQ_MUL,
    S_SP_SUB,
    S_ISQ,
    S_DEN_MUL,
    S_CMP,
    S_DIV,
    S_DONE
  } state_t;

endpackage

// ===== hdl/pck_in_if.sv =====
interface pck_in_if;
  import pck_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] x_sample;
  logic [SAMPLE_W-1:0] y_sample;

  modport source (output valid, x_sample, y_sample, input ready);
  modport sink (input valid, x_sample, y_sample, output ready);
endinterface

// ===== hdl/pck_out_if.sv =====
interface pck_out_if;
  import pck_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [CORR_W-1:0] correlation;
  logic                     valid_res;

  modport source (output valid, correlation, valid_res, input ready);
  modport sink (input valid, correlation, valid_res, output ready);
endinterface

// ===== hdl/pck_alu.sv =====
module pck_alu (
  input  pck_pkg::alu_req_t req,
  output pck_pkg::alu_rsp_t rsp
);
  import pck_pkg::*;

  logic [DW:0]          diff;
  logic [2*MUL_W-1:0]   prod;

  // One adder, one subtractor with borrow out and one 32 by 32 multiplier.
  always_comb begin
    diff       = {1'b0, req.a} - {1'b0, req.b};
    prod       = req.a[MUL_W-1:0] * req.b[MUL_W-1:0];
    rsp.borrow = diff[DW];
    unique case (req.op)
      ALU_ADD: rsp.y = req.a + req.b;
      ALU_SUB: rsp.y = diff[DW-1:0];
      ALU_MUL: rsp.y = DW'(prod);
      default: rsp.y = '0;
    endcase
  end

endmodule

// ===== hdl/pearson_correlation_kernel.sv =====
// Pearson correlation over groups of RECORD_LEN sample pairs.
// Input channel samples carries x_sample and y_sample; output channel result carries
// correlation (signed Q1.15, clamped to +/-32767) and valid_res (0 when either series
// has zero spread, in which case correlation is 0). Both use valid/ready.
// For each pair, ready is high only in the idle state, and the pair then runs 8
// operations (three products, five sums) through the one shared arithmetic unit.
// After the last pair of a group the same unit computes the numerator, both square
// roots (32 steps each) and the Q1.15 quotient (15 steps). No item is taken while
// this runs; the result register is then loaded.
// The result register lets the next group start while a result waits. If a new result
// is ready before the old one is taken, the sequencer holds until the receiver takes it.
// Synchronous reset clears all sums, the pair count and the result valid flag.
module pearson_correlation_kernel (
  input logic       clk,
  input logic       rst,
  pck_in_if.sink    samples,
  pck_out_if.source result
);
  import pck_pkg::*;

  state_t                   state;
  state_t                   state_next;
  alu_req_t                 req;
  alu_rsp_t                 rsp;

  logic [N_W-1:0]           count;
  logic [SUM_W-1:0]         sum_x;
  logic [SUM_W-1:0]         sum_y;
  logic [SQ_W-1:0]          sum_xx;
  logic [SQ_W-1:0]          sum_yy;
  logic [SQ_W-1:0]          sum_xy;

  logic [SAMPLE_W-1:0]      x_sat;
  logic [SAMPLE_W-1:0]      y_sat;
  logic [DW-1:0]            acc;
  logic [DW-1:0]            opa;
  logic [DW-1:0]            rem;
  logic [DW-1:0]            den;
  logic [N_W-1:0]           nsh;
  logic [STEP_W-1:0]        step;
  logic                     neg;
  logic                     pass_y;
  logic [DW-1:0]            sq_v;
  logic [DW-1:0]            sq_rem;
  logic [MUL_W-1:0]         sq_root;
  logic [MUL_W-1:0]         root_x;
  logic [Q_W-1:0]           quo;
  logic                     defined;

  logic                     out_valid;
  logic signed [CORR_W-1:0] out_corr;
  logic                     out_def;

  logic                     accept;
  logic                     done_load;
  logic [DW-1:0]            sa_src;
  logic [DW-1:0]            sa_add;
  logic [SUM_W-1:0]         sq_sel;
  logic [DW-1:0]            isq_cur;
  logic [DW-1:0]            isq_trial;
  logic [MUL_W-1:0]         root_upd;
  logic [DW-1:0]            div_shift;
  logic                     div_take;
  logic [CORR_W-1:0]        corr_mag;
  logic [CORR_W-1:0]        corr_val;

  pck_alu u_alu (
    .req (req),
    .rsp (rsp)
  );

  // Handshake and port drive.
  assign samples.ready      = (state == S_IDLE);
  assign accept             = samples.valid && samples.ready;
  assign done_load          = (state == S_DONE) && (!out_valid || result.ready);
  assign result.valid       = out_valid;
  assign result.correlation = out_corr;
  assign result.valid_res   = out_def;

  // Operand shaping for the shift-add multiply by the group length.
  assign sa_src = (state == S_NXY) ? DW'(sum_xy) : (pass_y ? DW'(sum_yy) : DW'(sum_xx));
  assign sa_add = nsh[N_W-1] ? sa_src : '0;
  assign sq_sel = pass_y ? sum_y : sum_x;

  // Square root digit recurrence: bring down two bits, try (4*root + 1).
  assign isq_cur   = {sq_rem[DW-3:0], sq_v[DW-1:DW-2]};
  assign isq_trial = DW'({sq_root, 2'b01});
  assign root_upd  = {sq_root[MUL_W-2:0], !rsp.borrow};

  // Restoring division step; the bit shifted out of the top always allows a subtract.
  assign div_shift = {rem[DW-2:0], 1'b0};
  assign div_take  = rem[DW-1] || !rsp.borrow;

  // Signed result from magnitude and sign.
  assign corr_mag = {1'b0, quo};
  assign corr_val = neg ? (CORR_W'(0) - corr_mag) : corr_mag;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and the operation issued to the shared unit.
  always_comb begin
    state_next = state;
    req.op     = ALU_ADD;
    req.a      = '0;
    req.b      = '0;
    unique case (state)
      S_IDLE: begin
        if (samples.valid) state_next = S_XX_MUL;
      end
      S_XX_MUL: begin
        req.op     = ALU_MUL;
        req.a      = DW'(x_sat);
        req.b      = DW'(x_sat);
        state_next = S_XX_ADD;
      end
      S_XX_ADD: begin
        req.a      = DW'(sum_xx);
        req.b      = acc;
        state_next = S_YY_MUL;
      end
      S_YY_MUL: begin
        req.op     = ALU_MUL;
        req.a      = DW'(y_sat);
        req.b      = DW'(y_sat);
        state_next = S_YY_ADD;
      end
      S_YY_ADD: begin
        req.a      = DW'(sum_yy);
        req.b      = acc;
        state_next = S_XY_MUL;
      end
      S_XY_MUL: begin
        req.op     = ALU_MUL;
        req.a      = DW'(x_sat);
        req.b      = DW'(y_sat);
        state_next = S_XY_ADD;
      end
      S_XY_ADD: begin
        req.a      = DW'(sum_xy);
        req.b      = acc;
        state_next = S_SX_ADD;
      end
      S_SX_ADD: begin
        req.a      = DW'(sum_x);
        req.b      = DW'(x_sat);
        state_next = S_SY_ADD;
      end
      S_SY_ADD: begin
        req.a      = DW'(sum_y);
        req.b      = DW'(y_sat);
        state_next = (count == N_CONST) ? S_NXY : S_IDLE;
      end
      S_NXY: begin
        req.a = {acc[DW-2:0], 1'b0};
        req.b = sa_add;
        if (step == '0) state_next = S_SXSY_MUL;
      end
      S_SXSY_MUL: begin
        req.op     = ALU_MUL;
        req.a      = DW'(sum_x);
        req.b      = DW'(sum_y);
        state_next = S_MAG_AB;
      end
      S_MAG_AB: begin
        req.op     = ALU_SUB;
        req.a      = opa;
        req.b      = acc;
        state_next = S_MAG_BA;
      end
      S_MAG_BA: begin
        req.op     = ALU_SUB;
        req.a      = acc;
        req.b      = opa;
        state_next = S_NSQ;
      end
      S_NSQ: begin
        req.a = {acc[DW-2:0], 1'b0};
        req.b = sa_add;
        if (step == '0) state_next = S_SQ_MUL;
      end
      S_SQ_MUL: begin
        req.op     = ALU_MUL;
        req.a      = DW'(sq_sel);
        req.b      = DW'(sq_sel);
        state_next = S_SP_SUB;
      end
      S_SP_SUB: begin
        req.op     = ALU_SUB;
        req.a      = rem;
        req.b      = acc;
        state_next = S_ISQ;
      end
      S_ISQ: begin
        req.op = ALU_SUB;
        req.a  = isq_cur;
        req.b  = isq_trial;
        if (step == '0) state_next = pass_y ? S_DEN_MUL : S_NSQ;
      end
      S_DEN_MUL: begin
        req.op     = ALU_MUL;
        req.a      = DW'(root_x);
        req.b      = DW'(sq_root);
        state_next = S_CMP;
      end
      S_CMP: begin
        req.op = ALU_SUB;
        req.a  = opa;
        req.b  = den;
        if (den == '0 || !rsp.borrow) begin
          state_next = S_DONE;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        req.op = ALU_SUB;
        req.a  = div_shift;
        req.b  = den;
        if (step == '0) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || result.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Running sums, pair count and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      sum_x     <= '0;
      sum_y     <= '0;
      sum_xx    <= '0;
      sum_yy    <= '0;
      sum_xy    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) count <= count + N_W'(1);
      if (state == S_XX_ADD) sum_xx <= rsp.y[SQ_W-1:0];
      if (state == S_YY_ADD) sum_yy <= rsp.y[SQ_W-1:0];
      if (state == S_XY_ADD) sum_xy <= rsp.y[SQ_W-1:0];
      if (state == S_SX_ADD) sum_x <= rsp.y[SUM_W-1:0];
      if (state == S_SY_ADD) sum_y <= rsp.y[SUM_W-1:0];
      if (done_load) begin
        count     <= '0;
        sum_x     <= '0;
        sum_y     <= '0;
        sum_xx    <= '0;
        sum_yy    <= '0;
        sum_xy    <= '0;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Work registers of the finishing sequence and the result payload.
  always_ff @(posedge clk) begin
    if (done_load) begin
      out_corr <= $signed(corr_val);
      out_def  <= defined;
    end
    unique case (state)
      S_IDLE: begin
        if (samples.valid) begin
          x_sat <= (samples.x_sample > SAMPLE_TOP) ? SAMPLE_TOP : samples.x_sample;
          y_sat <= (samples.y_sample > SAMPLE_TOP) ? SAMPLE_TOP : samples.y_sample;
        end
      end
      S_XX_MUL, S_YY_MUL, S_XY_MUL: begin
        acc <= rsp.y;
      end
      S_SY_ADD: begin
        acc  <= '0;
        nsh  <= N_CONST;
        step <= STEP_W'(N_W - 1);
      end
      S_NXY, S_NSQ: begin
        acc  <= rsp.y;
        nsh  <= {nsh[N_W-2:0], 1'b0};
        step <= step - STEP_W'(1);
      end
      S_SXSY_MUL: begin
        opa <= acc;
        acc <= rsp.y;
      end
      S_MAG_AB: begin
        rem <= rsp.y;
        neg <= rsp.borrow;
      end
      S_MAG_BA: begin
        // Magnitude of the numerator; the sign was taken in the step before.
        opa    <= neg ? rsp.y : rem;
        acc    <= '0;
        nsh    <= N_CONST;
        step   <= STEP_W'(N_W - 1);
        pass_y <= 1'b0;
      end
      S_SQ_MUL: begin
        rem <= acc;
        acc <= rsp.y;
      end
      S_SP_SUB: begin
        // A spread that would go negative is taken as zero.
        sq_v    <= rsp.borrow ? '0 : rsp.y;
        sq_rem  <= '0;
        sq_root <= '0;
        step    <= STEP_W'(ISQ_STEPS - 1);
      end
      S_ISQ: begin
        sq_v    <= {sq_v[DW-3:0], 2'b00};
        sq_rem  <= rsp.borrow ? isq_cur : rsp.y;
        sq_root <= root_upd;
        if (step == '0 && !pass_y) begin
          root_x <= root_upd;
          pass_y <= 1'b1;
          acc    <= '0;
          nsh    <= N_CONST;
          step   <= STEP_W'(N_W - 1);
        end else begin
          step <= step - STEP_W'(1);
        end
      end
      S_DEN_MUL: begin
        den <= rsp.y;
      end
      S_CMP: begin
        if (den == '0) begin
          defined <= 1'b0;
          quo     <= '0;
        end else if (!rsp.borrow) begin
          // Magnitude at or above the denominator clamps to full scale.
          defined <= 1'b1;
          quo     <= '1;
        end else begin
          defined <= 1'b1;
          quo     <= '0;
          rem     <= opa;
          step    <= STEP_W'(Q_W - 1);
        end
      end
      S_DIV: begin
        rem  <= div_take ? rsp.y : div_shift;
        quo  <= {quo[Q_W-2:0], div_take};
        step <= step - STEP_W'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/pck_chk.sv =====
`include "pearson_correlation_kernel_assert.svh"

module pck_chk (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [pck_pkg::CORR_W-1:0] correlation,
  input logic                             valid_res
);
  import pck_pkg::*;

  // The block works on one item at a time, so it is busy right after taking one.
  `PCK_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)

  // A stalled result stays put.
  `PCK_ASSERT_NEXT(a_result_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(correlation) && $stable(valid_res))

  // An undefined coefficient is reported as zero.
  `PCK_ASSERT_NOW(a_undefined_is_zero, clk, rst, out_valid && !valid_res, correlation == '0)

  // The clamp keeps the most negative code out.
  `PCK_ASSERT_NOW(a_clamped, clk, rst, out_valid, correlation != {1'b1, {(CORR_W-1){1'b0}}})

endmodule

bind pearson_correlation_kernel pck_chk u_pck_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (samples.valid),
  .in_ready    (samples.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .correlation (result.correlation),
  .valid_res   (result.valid_res)
);
